// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sssp_pkg.sv =====
package sssp_pkg;

  localparam int MAX_NODES   = 64;
  localparam int MAX_EDGES   = 256;
  localparam int WEIGHT_BITS = 16;

  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int EDGE_W  = $clog2(MAX_EDGES);
  localparam int NCNT_W  = $clog2(MAX_NODES + 1);
  localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
  localparam int DIST_W  = 32;
  localparam int NCFG_W  = 7;
  localparam int ECFG_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RELAX,
    S_OUT_RD,
    S_OUT_LD,
    S_NEG
  } state_t;

  typedef struct packed {
    logic                          func;
    logic [EDGE_W-1:0]             edge_index;
    logic [NODE_W-1:0]             edge_from;
    logic [NODE_W-1:0]             edge_to;
    logic signed [WEIGHT_BITS-1:0] edge_weight;
    logic [NODE_W-1:0]             start_vertex;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]        vertex;
    logic signed [DIST_W-1:0] path_length;
    logic                     reached;
    logic [NODE_W-1:0]        parent_vertex;
    logic                     negative_cycle;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]             from;
    logic [NODE_W-1:0]             to;
    logic signed [WEIGHT_BITS-1:0] weight;
  } edge_t;

  // Control from the sequencer to the vertex state.
  typedef struct packed {
    logic              init;
    logic              start_ok;
    logic [NODE_W-1:0] start;
    logic [NCNT_W-1:0] n_run;
    logic              s1_v;
    logic              s1_chk;
    logic              out_sel;
    logic [NODE_W-1:0] out_v;
  } vctl_t;

  typedef struct packed {
    logic busy;
    logic neg;
  } vsts_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] dist_val;
    logic                     reached;
    logic [NODE_W-1:0]        parent;
  } vdata_t;

endpackage

// ===== hw/rtl/single_source_shortest_path.sv =====
// Channel   Ports                                    Dir   Carries
// input     in_valid/in_ready/in_data                in    edge load or run request
// result    out_valid/out_ready/out_data             out   per-vertex result or cycle flag
// config    cfg_valid/cfg_ready/cfg_index/cfg_data   in    node_count, edge_count writes
//
// An edge load writes the edge memory on acceptance. A run streams the edge list from the edge
// memory read port, one edge relaxed per cycle over a three-stage read-modify-write pipeline
// (n passes plus one check pass for n vertices), then sends one result per vertex, or a single
// negative cycle report.
// Result output stalls while out_ready is low; input is taken only when idle.
// Reset: synchronous active-low rst_n clears control and reached marks; no sweep.
`include "assert_macros.svh"

module single_source_shortest_path
  import sssp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [NCFG_W-1:0] ncfg_r;
  logic [ECFG_W-1:0] ecfg_r;
  logic [NCNT_W-1:0] n_eff, n_run_r, pass_r, pass_nxt;
  logic [ECNT_W-1:0] m_eff, m_run_r, j_r, j_nxt;
  logic [NODE_W-1:0] start_r, v_r, v_nxt;
  logic              start_ok_r;
  logic              issuing_r, issuing_nxt;
  logic              s1_v_r, s1_chk_r, issue;
  edge_t             edge_mem [MAX_EDGES];
  edge_t             edge_q;

  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt, out_load, slot_free;

  logic   in_fire, run_fire, load_fire, cfg_fire, drain, v_last, last_edge;
  vctl_t  vctl;
  vsts_t  vsts;
  vdata_t vdata;

  assign in_fire   = in_valid && in_ready;
  assign run_fire  = in_fire && in_data.func == FUNC_RUN;
  assign load_fire = in_fire && in_data.func == FUNC_LOAD;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (ncfg_r == '0) begin
      n_eff = NCNT_W'(1);
    end else if (NCNT_W'(ncfg_r) > NCNT_W'(MAX_NODES)) begin
      n_eff = NCNT_W'(MAX_NODES);
    end else begin
      n_eff = NCNT_W'(ncfg_r);
    end
    m_eff = (ECNT_W'(ecfg_r) > ECNT_W'(MAX_EDGES)) ? ECNT_W'(MAX_EDGES) : ECNT_W'(ecfg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncfg_r <= NCFG_W'(MAX_NODES);
      ecfg_r <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_NODE_COUNT: ncfg_r <= cfg_data[NCFG_W-1:0];
        CFG_EDGE_COUNT: ecfg_r <= cfg_data[ECFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Edge memory: written by loads, streamed out during a run.
  always_ff @(posedge clk) begin
    if (load_fire) begin
      edge_mem[in_data.edge_index] <= '{from:   in_data.edge_from,
                                        to:     in_data.edge_to,
                                        weight: in_data.edge_weight};
    end
    edge_q <= edge_mem[j_r[EDGE_W-1:0]];
  end

  assign issue     = state_r == S_RELAX && issuing_r;
  assign last_edge = j_r == m_run_r - ECNT_W'(1);
  assign drain     = !issuing_r && !s1_v_r && !vsts.busy;
  assign v_last    = NCNT_W'(v_r) == n_run_r - NCNT_W'(1);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (run_fire) state_nxt = S_RELAX;
      end
      S_RELAX: begin
        if (drain) state_nxt = vsts.neg ? S_NEG : S_OUT_RD;
      end
      S_OUT_RD: state_nxt = S_OUT_LD;
      S_OUT_LD: begin
        if (slot_free) state_nxt = v_last ? S_IDLE : S_OUT_RD;
      end
      S_NEG: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = state_r == S_IDLE;
    j_nxt       = j_r;
    pass_nxt    = pass_r;
    issuing_nxt = issuing_r;
    v_nxt       = v_r;
    out_load    = (state_r == S_OUT_LD || state_r == S_NEG) && slot_free;
    out_nxt     = out_r;
    case (state_r)
      S_IDLE: begin
        if (run_fire) begin
          j_nxt       = '0;
          pass_nxt    = '0;
          issuing_nxt = m_eff != '0;
        end
      end
      S_RELAX: begin
        v_nxt = '0;
        if (issue) begin
          if (last_edge) begin
            j_nxt = '0;
            if (pass_r == n_run_r) begin
              issuing_nxt = 1'b0;
            end else begin
              pass_nxt = pass_r + NCNT_W'(1);
            end
          end else begin
            j_nxt = j_r + ECNT_W'(1);
          end
        end
      end
      S_OUT_LD: begin
        if (out_load) begin
          out_nxt.vertex         = v_r;
          out_nxt.path_length    = vdata.reached ? vdata.dist_val : '0;
          out_nxt.reached        = vdata.reached;
          out_nxt.parent_vertex  = vdata.reached ? vdata.parent : v_r;
          out_nxt.negative_cycle = 1'b0;
          out_nxt.last           = v_last;
          v_nxt = v_r + NODE_W'(1);
        end
      end
      S_NEG: begin
        if (out_load) begin
          out_nxt.vertex         = start_r;
          out_nxt.path_length    = '0;
          out_nxt.reached        = 1'b0;
          out_nxt.parent_vertex  = '0;
          out_nxt.negative_cycle = 1'b1;
          out_nxt.last           = 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issuing_r   <= 1'b0;
      s1_v_r      <= 1'b0;
      s1_chk_r    <= 1'b0;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      pass_r      <= '0;
      v_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      issuing_r   <= issuing_nxt;
      s1_v_r      <= issue;
      s1_chk_r    <= pass_r == n_run_r;
      out_valid_r <= out_valid_nxt;
      j_r         <= j_nxt;
      pass_r      <= pass_nxt;
      v_r         <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (run_fire) begin
      n_run_r    <= n_eff;
      m_run_r    <= m_eff;
      start_r    <= in_data.start_vertex;
      start_ok_r <= NCNT_W'(in_data.start_vertex) < n_eff;
    end
  end

  always_comb begin
    vctl.init     = run_fire;
    vctl.start_ok = NCNT_W'(in_data.start_vertex) < n_eff;
    vctl.start    = in_data.start_vertex;
    vctl.n_run    = n_run_r;
    vctl.s1_v     = s1_v_r;
    vctl.s1_chk   = s1_chk_r;
    vctl.out_sel  = state_r == S_OUT_RD || state_r == S_OUT_LD;
    vctl.out_v    = v_r;
  end

  sssp_vtx u_vtx (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (vctl),
    .s1_edge (edge_q),
    .sts     (vsts),
    .vdata   (vdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_IMPLY(a_drain_empty, clk, rst_n, state_r == S_RELAX && state_nxt != S_RELAX, !s1_v_r && !vsts.busy, "relax pipeline not empty at end of run")
  `ASSERT_IMPLY(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready, !out_load, "pending result overwritten")
  `ASSERT_NEXT(a_last_idle, clk, rst_n, out_load && out_nxt.last, state_r == S_IDLE, "final result did not return to idle")
  `ASSERT_IMPLY(a_neg_unreached, clk, rst_n, state_r == S_NEG, !start_ok_r || vsts.neg, "cycle flag lost before report")

endmodule

// ===== hw/rtl/sssp_vtx.sv =====
// Per-vertex distance/parent memories, reached marks and the relax stage.
module sssp_vtx
  import sssp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  vctl_t  ctl,
  input  edge_t  s1_edge,
  output vsts_t  sts,
  output vdata_t vdata
);

  logic signed [DIST_W-1:0] dist_mem [MAX_NODES];
  logic [NODE_W-1:0]        par_mem  [MAX_NODES];

  logic signed [DIST_W-1:0] dist_a_q;
  logic signed [DIST_W-1:0] dist_b_q;
  logic [NODE_W-1:0]        par_q;
  logic [NODE_W-1:0]        rd_addr_a;

  logic [MAX_NODES-1:0] reached_r, reached_nxt;
  logic                 s2_v_r, s2_chk_r;
  edge_t                s2_edge_r;
  logic                 wr_v_r, wr_v_nxt;
  logic [NODE_W-1:0]    wr_addr_r;
  logic signed [DIST_W-1:0] wr_dist_r;
  logic                 neg_r, neg_nxt;

  logic signed [DIST_W-1:0] dist_f, dist_t, sat;
  logic signed [DIST_W:0]   cand;
  logic                     in_range, less, improve, upd;

  assign rd_addr_a = ctl.out_sel ? ctl.out_v : s1_edge.from;

  // One write port, two read ports; reads see the old contents.
  // Start vertex sits at distance zero with itself as parent.
  always_ff @(posedge clk) begin
    if (upd) begin
      dist_mem[s2_edge_r.to] <= sat;
      par_mem[s2_edge_r.to]  <= s2_edge_r.from;
    end else if (ctl.init) begin
      dist_mem[ctl.start] <= '0;
      par_mem[ctl.start]  <= ctl.start;
    end
    dist_a_q <= dist_mem[rd_addr_a];
    dist_b_q <= dist_mem[s1_edge.to];
    par_q    <= par_mem[ctl.out_v];
  end

  // Bypass the last write, which the registered reads just missed.
  always_comb begin
    dist_f = (wr_v_r && wr_addr_r == s2_edge_r.from) ? wr_dist_r : dist_a_q;
    dist_t = (wr_v_r && wr_addr_r == s2_edge_r.to) ? wr_dist_r : dist_b_q;
    in_range = ({1'b0, s2_edge_r.from} < ctl.n_run) && ({1'b0, s2_edge_r.to} < ctl.n_run);
    cand = {dist_f[DIST_W-1], dist_f}
         + {{(DIST_W + 1 - WEIGHT_BITS){s2_edge_r.weight[WEIGHT_BITS-1]}}, s2_edge_r.weight};
    less = cand < $signed({dist_t[DIST_W-1], dist_t});
    improve = s2_v_r && in_range && reached_r[s2_edge_r.from]
           && (!reached_r[s2_edge_r.to] || less);
    upd = improve && !s2_chk_r;
    if (cand[DIST_W] != cand[DIST_W-1]) begin
      sat = cand[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      sat = cand[DIST_W-1:0];
    end
  end

  always_comb begin
    reached_nxt = reached_r;
    neg_nxt     = neg_r;
    wr_v_nxt    = upd;
    if (ctl.init) begin
      reached_nxt = '0;
      if (ctl.start_ok) begin
        reached_nxt[ctl.start] = 1'b1;
      end
      neg_nxt = 1'b0;
    end else begin
      if (upd) begin
        reached_nxt[s2_edge_r.to] = 1'b1;
      end
      if (improve && s2_chk_r) begin
        neg_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_r <= '0;
      s2_v_r    <= 1'b0;
      s2_chk_r  <= 1'b0;
      wr_v_r    <= 1'b0;
      neg_r     <= 1'b0;
    end else begin
      reached_r <= reached_nxt;
      s2_v_r    <= ctl.s1_v;
      s2_chk_r  <= ctl.s1_chk;
      wr_v_r    <= wr_v_nxt;
      neg_r     <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_edge_r <= s1_edge;
    wr_addr_r <= s2_edge_r.to;
    wr_dist_r <= sat;
  end

  assign sts.busy       = s2_v_r;
  assign sts.neg        = neg_r;
  assign vdata.dist_val = dist_a_q;
  assign vdata.parent   = par_q;
  assign vdata.reached  = reached_r[ctl.out_v];

endmodule

// ===== test/single_source_shortest_path_tb.sv =====
`timescale 1ns / 1ps

module single_source_shortest_path_tb;
  import sssp_pkg::*;

  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 70;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_NODE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  single_source_shortest_path uut (.*);

  always #10 clk = ~clk;

  // Shadow copy of the block: edge list, per-vertex state, registers
  logic [NODE_W-1:0]             arc_from [MAX_EDGES];
  logic [NODE_W-1:0]             arc_to   [MAX_EDGES];
  logic signed [WEIGHT_BITS-1:0] arc_wt   [MAX_EDGES];
  logic signed [DIST_W-1:0]      dist_m   [MAX_NODES];
  bit                            reach_m  [MAX_NODES];
  logic [NODE_W-1:0]             parent_m [MAX_NODES];
  int unsigned                   node_reg = 64;
  int unsigned                   edge_reg = 0;

  out_item_t paths_due[$];
  in_item_t  items_q[$];
  bit        slot_written [MAX_EDGES];

  bit in_taken = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  bit quiet = 1'b0;
  bit hold_on = 1'b0;
  bit hold_done = 1'b0;
  int error_count = 0;
  int cycle_count = 0;

  // One pass over the edge list; returns 1 if any distance could still shrink.
  function automatic bit relax_edges(input int n, input int m, input bit apply);
    bit     shortened;
    longint cand;
    int     f, t, j;
    shortened = 1'b0;
    for (j = 0; j < m; j++) begin
      f = int'(arc_from[j]);
      t = int'(arc_to[j]);
      if (f < n && t < n && reach_m[f]) begin
        cand = longint'(dist_m[f]) + longint'(arc_wt[j]);
        if (!reach_m[t] || cand < longint'(dist_m[t])) begin
          shortened = 1'b1;
          if (!apply) return 1'b1;
          if (cand > 64'sd2147483647) dist_m[t] = 32'sh7fffffff;
          else if (cand < -64'sd2147483648) dist_m[t] = 32'sh80000000;
          else dist_m[t] = cand[31:0];
          reach_m[t] = 1'b1;
          parent_m[t] = NODE_W'(f);
        end
      end
    end
    return shortened;
  endfunction

  function automatic void apply_request(input in_item_t it);
    int        n, m, s, v, p;
    out_item_t r;
    if (it.func == FUNC_LOAD) begin
      arc_from[it.edge_index] = it.edge_from;
      arc_to[it.edge_index]   = it.edge_to;
      arc_wt[it.edge_index]   = it.edge_weight;
    end else begin
      n = (node_reg == 0) ? 1 : (node_reg > MAX_NODES) ? MAX_NODES : int'(node_reg);
      m = (edge_reg > MAX_EDGES) ? MAX_EDGES : int'(edge_reg);
      s = int'(it.start_vertex);
      for (v = 0; v < MAX_NODES; v++) begin
        dist_m[v]   = '0;
        reach_m[v]  = 1'b0;
        parent_m[v] = NODE_W'(v);
      end
      if (s < n) reach_m[s] = 1'b1;
      for (p = 0; p < n; p++) void'(relax_edges(n, m, 1'b1));
      if (relax_edges(n, m, 1'b0)) begin
        r = '0;
        r.vertex = it.start_vertex;
        r.negative_cycle = 1'b1;
        r.last = 1'b1;
        paths_due = {paths_due, r};
      end else begin
        for (v = 0; v < n; v++) begin
          r.vertex         = NODE_W'(v);
          r.path_length    = reach_m[v] ? dist_m[v] : '0;
          r.reached        = reach_m[v];
          r.parent_vertex  = reach_m[v] ? parent_m[v] : NODE_W'(v);
          r.negative_cycle = 1'b0;
          r.last           = (v == n - 1);
          paths_due = {paths_due, r};
        end
      end
    end
  endfunction

  function automatic string path_str(input out_item_t r);
    return $sformatf("v=%0d len=%0d reached=%0b parent=%0d neg=%0b last=%0b",
                     r.vertex, r.path_length, r.reached, r.parent_vertex,
                     r.negative_cycle, r.last);
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else if (items_q.size() != 0) begin
        in_data <= items_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    if (hold_on && !hold_done) begin
      out_ready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_gap <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Long receiver hold-off, counted here once the stimulus arms it
  initial begin
    wait (hold_on);
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_done = 1'b1;
  end

  // Monitor: predict on input transfer, check on result transfer
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) apply_request(in_data);
      if (out_valid && out_ready) begin
        if (paths_due.size() == 0) begin
          flag_error({"unexpected result: ", path_str(out_data)});
        end else begin
          want = paths_due.pop_front();
          if (out_data.vertex !== want.vertex ||
              out_data.path_length !== want.path_length ||
              out_data.reached !== want.reached ||
              out_data.parent_vertex !== want.parent_vertex ||
              out_data.negative_cycle !== want.negative_cycle ||
              out_data.last !== want.last)
            flag_error({"expected ", path_str(want), " got ", path_str(out_data)});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void add_load(input int slot, input int src, input int dst,
                                   input int w);
    in_item_t it;
    it.func         = FUNC_LOAD;
    it.edge_index   = EDGE_W'(slot);
    it.edge_from    = NODE_W'(src);
    it.edge_to      = NODE_W'(dst);
    it.edge_weight  = WEIGHT_BITS'(w);
    it.start_vertex = NODE_W'($urandom_range(0, 63));
    items_q = {items_q, it};
    slot_written[slot] = 1'b1;
  endfunction

  function automatic void add_random_load(input int slot, input int n);
    int src, dst, w, pick;
    src = ($urandom_range(0, 6) != 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
    dst = ($urandom_range(0, 6) != 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
    pick = $urandom_range(0, 19);
    if (pick < 13) w = $urandom_range(0, 50);
    else if (pick < 17) w = -$urandom_range(0, 8);
    else w = $signed(16'($urandom));
    add_load(slot, src, dst, w);
  endfunction

  function automatic void add_run(input int start);
    in_item_t it;
    it.func         = FUNC_RUN;
    it.edge_index   = EDGE_W'($urandom_range(0, 255));
    it.edge_from    = NODE_W'($urandom_range(0, 63));
    it.edge_to      = NODE_W'($urandom_range(0, 63));
    it.edge_weight  = WEIGHT_BITS'($urandom);
    it.start_vertex = NODE_W'(start);
    items_q = {items_q, it};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_NODE_COUNT) node_reg = value & 32'h7f;
    else edge_reg = value & 32'h1ff;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every item is taken and every result has come back
  task automatic settle();
    @(posedge clk);
    while (items_q.size() != 0 || in_valid || paths_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int n, m, k, j, runs, rand_items;
    rand_items = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset config: 64 vertices, empty edge list
    add_run(0);
    add_run(63);
    settle();

    // weight extremes, out-of-graph tail/head, start outside the graph
    write_reg(CFG_NODE_COUNT, 4);
    write_reg(CFG_EDGE_COUNT, 6);
    add_load(0, 0, 1, 32767);
    add_load(1, 1, 2, -32768);
    add_load(2, 0, 2, 5);
    add_load(3, 2, 3, 0);
    add_load(4, 63, 1, 7);
    add_load(5, 3, 63, -1);
    add_load(255, 63, 63, -32768);
    add_run(0);
    add_run(3);
    add_run(2);
    add_run(5);
    add_run(63);
    settle();

    // reachable negative cycle 0->1->2->0
    write_reg(CFG_NODE_COUNT, 3);
    write_reg(CFG_EDGE_COUNT, 8);
    add_load(6, 2, 0, -10);
    add_load(7, 1, 0, 40);
    add_run(0);
    add_run(5);
    settle();

    // node_count of zero behaves as one vertex
    write_reg(CFG_NODE_COUNT, 0);
    write_reg(CFG_EDGE_COUNT, 0);
    add_run(0);
    add_run(1);
    settle();

    write_reg(CFG_NODE_COUNT, 2);
    write_reg(CFG_EDGE_COUNT, 8);
    add_run(1);
    settle();

    // full vertex count
    write_reg(CFG_NODE_COUNT, 64);
    write_reg(CFG_EDGE_COUNT, 8);
    add_run($urandom_range(0, 63));
    settle();
    // node_count beyond the store size clamps
    write_reg(CFG_NODE_COUNT, 127);
    add_run($urandom_range(0, 63));
    settle();

    // receiver holds off while more items are offered
    write_reg(CFG_NODE_COUNT, 5);
    write_reg(CFG_EDGE_COUNT, 6);
    add_run(0);
    for (j = 0; j < 4; j++) add_random_load(j, 5);
    add_run($urandom_range(0, 4));
    hold_on = 1'b1;
    settle();

    while (rand_items < RANDOM_ITEMS) begin
      quiet = (rand_items >= RANDOM_ITEMS * 4 / 5);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(2, 12);
      m = $urandom_range(0, 2 * n + 4);
      if (m > 24) m = 24;
      // every slot in use gets an edge before it is relaxed
      for (j = 0; j < m; j++) begin
        if (!slot_written[j]) begin
          add_random_load(j, n);
          rand_items++;
        end
      end
      k = $urandom_range(1, 4);
      for (j = 0; j < k; j++) begin
        if (m == 0) add_random_load($urandom_range(0, 255), n);
        else add_random_load($urandom_range(0, m - 1), n);
      end
      rand_items += k;
      settle();
      write_reg(CFG_NODE_COUNT, n);
      write_reg(CFG_EDGE_COUNT, m);
      runs = $urandom_range(1, 3);
      for (j = 0; j < runs; j++) begin
        if ($urandom_range(0, 4) != 0) add_run($urandom_range(0, n - 1));
        else add_run($urandom_range(0, 63));
      end
      rand_items += runs;
      settle();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
